// ===== rtl/can_filter_bank_packer_defines.svh =====
// Assertion macros shared by the filter bank packer RTL.
`ifndef CAN_FILTER_BANK_PACKER_DEFINES_SVH
`define CAN_FILTER_BANK_PACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CFBP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CFBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cfbp_pkg.sv =====
// Types and constants of the CAN filter bank packer.
package cfbp_pkg;

	localparam int KIND_LIST = 0;
	localparam int KIND_PAIR = 1;
	localparam int KIND_EXT  = 2;
	localparam int NUM_KINDS = 3;

	localparam int Q_DEPTH = 2;

	localparam logic [0:0] REG_FIRST_BANK = 1'd0;

	localparam logic [10:0] STD_ID_MAX = 11'h7FF;

	typedef enum logic [1:0] {
		MODE_LIST = 2'd0,
		MODE_PAIR = 2'd1,
		MODE_EXT  = 2'd2
	} bank_mode_t;

	typedef struct packed {
		logic [31:0] filter_id;
		logic [10:0] filter_mask;
		logic        last_entry;
	} entry_t;

	typedef struct packed {
		logic [7:0]  bank_number;
		bank_mode_t  bank_mode;
		logic        fifo_select;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
		logic        final_write;
	} bank_write_t;

	// Padded contents of one bank. Standard ids and masks sit in the low 11 bits of w0/w1.
	typedef struct packed {
		logic [28:0] w0;
		logic [28:0] w1;
		logic [10:0] w2;
		logic [10:0] w3;
	} bank_desc_t;

	// All writes caused by one entry.
	typedef struct packed {
		bank_desc_t [NUM_KINDS-1:0] desc;
		logic [NUM_KINDS-1:0]       valid;
		logic [NUM_KINDS-1:0]       first;
		logic                       last;
	} bundle_t;

endpackage

// ===== rtl/cfbp_front.sv =====
// Front end: sorts entries into the three bank stores and builds the bank writes.
module cfbp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cfbp_pkg::entry_t  entry,
	output cfbp_pkg::bundle_t bundle,
	output logic              has_write
);

	logic [10:0] list_q [4];
	logic [1:0]  list_fill_q;
	logic [10:0] pair_id_q;
	logic [10:0] pair_mask_q;
	logic        pair_fill_q;
	logic [28:0] ext_q;
	logic        ext_fill_q;

	logic        is_ext;
	logic        is_pair;
	logic        is_list;
	logic        last;
	logic [10:0] id_std;
	logic [28:0] id_ext;

	logic [10:0] list_post [4];
	logic [10:0] list_pick [4];
	logic [2:0]  list_cnt;
	logic [1:0]  list_last_idx;
	logic        list_full;
	logic        pair_full;
	logic        ext_full;
	logic [10:0] pair_id0;
	logic [10:0] pair_mask0;
	logic [10:0] pair_id1;
	logic [10:0] pair_mask1;
	logic [28:0] ext0;
	logic [28:0] ext1;

	assign is_ext  = |entry.filter_id[31:11];
	assign is_pair = !is_ext && (entry.filter_mask != 11'd0);
	assign is_list = !is_ext && !is_pair;
	assign last    = entry.last_entry;
	assign id_std  = entry.filter_id[10:0];
	assign id_ext  = entry.filter_id[28:0];

	assign list_cnt      = {1'b0, list_fill_q} + {2'b0, is_list};
	assign list_last_idx = list_cnt[1:0] - 2'd1;
	assign list_full     = list_cnt[2];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			list_post[i] = (is_list && (list_fill_q == 2'(i))) ? id_std : list_q[i];
		end
		for (int i = 0; i < 4; i++) begin
			list_pick[i] = (3'(i) < list_cnt) ? list_post[i] : list_post[list_last_idx];
		end
	end

	assign pair_full  = is_pair && pair_fill_q;
	assign pair_id0   = pair_fill_q ? pair_id_q : id_std;
	assign pair_mask0 = pair_fill_q ? pair_mask_q : entry.filter_mask;
	assign pair_id1   = pair_full ? id_std : pair_id0;
	assign pair_mask1 = pair_full ? entry.filter_mask : pair_mask0;

	assign ext_full = is_ext && ext_fill_q;
	assign ext0     = ext_fill_q ? ext_q : id_ext;
	assign ext1     = ext_full ? id_ext : ext0;

	always_comb begin
		bundle = '0;
		bundle.desc[cfbp_pkg::KIND_LIST] = '{w0: {18'd0, list_pick[0]}, w1: {18'd0, list_pick[1]},
			w2: list_pick[2], w3: list_pick[3]};
		bundle.desc[cfbp_pkg::KIND_PAIR] = '{w0: {18'd0, pair_id0}, w1: {18'd0, pair_mask0},
			w2: pair_id1, w3: pair_mask1};
		bundle.desc[cfbp_pkg::KIND_EXT] = '{w0: ext0, w1: ext1, w2: 11'd0, w3: 11'd0};
		bundle.first[cfbp_pkg::KIND_LIST] = list_full;
		bundle.first[cfbp_pkg::KIND_PAIR] = pair_full;
		bundle.first[cfbp_pkg::KIND_EXT]  = ext_full;
		bundle.valid[cfbp_pkg::KIND_LIST] = list_full || (last && (list_cnt != 3'd0));
		bundle.valid[cfbp_pkg::KIND_PAIR] = pair_full || (last && (pair_fill_q || is_pair));
		bundle.valid[cfbp_pkg::KIND_EXT]  = ext_full || (last && (ext_fill_q || is_ext));
		bundle.last = last;
	end

	assign has_write = |bundle.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_fill_q <= '0;
			pair_fill_q <= 1'b0;
			ext_fill_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				list_fill_q <= '0;
				pair_fill_q <= 1'b0;
				ext_fill_q  <= 1'b0;
			end else begin
				list_fill_q <= list_cnt[1:0];
				if (is_pair) begin
					pair_fill_q <= !pair_fill_q;
				end
				if (is_ext) begin
					ext_fill_q <= !ext_fill_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_list) begin
				list_q[list_fill_q] <= id_std;
			end
			if (is_pair && !pair_fill_q) begin
				pair_id_q   <= id_std;
				pair_mask_q <= entry.filter_mask;
			end
			if (is_ext && !ext_fill_q) begin
				ext_q <= id_ext;
			end
		end
	end

endmodule

// ===== rtl/cfbp_queue.sv =====
// Short queue of write bundles between front and back end.
module cfbp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  cfbp_pkg::bundle_t wr_data,
	input  logic              rd_en,
	output cfbp_pkg::bundle_t rd_data,
	output logic              avail,
	output logic              full
);

	localparam int PTR_W = (cfbp_pkg::Q_DEPTH > 1) ? $clog2(cfbp_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(cfbp_pkg::Q_DEPTH + 1);

	cfbp_pkg::bundle_t entries_q [cfbp_pkg::Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign avail   = (count_q != '0);
	assign full    = (count_q == CNT_W'(cfbp_pkg::Q_DEPTH));
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && avail;
	assign rd_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(cfbp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(cfbp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/cfbp_back.sv =====
// Back end: issues one bank write per cycle while the output is free or popped, numbers banks, formats the words.
module cfbp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfbp_pkg::bundle_t     head,
	input  logic                  head_valid,
	output logic                  head_done,
	input  logic [7:0]            first_bank,
	input  logic                  bank_load,
	input  logic                  pop,
	output logic                  empty,
	output cfbp_pkg::bank_write_t bank_write
);

	logic [cfbp_pkg::NUM_KINDS-1:0] done_q;
	logic [cfbp_pkg::NUM_KINDS-1:0] pending;
	logic [cfbp_pkg::NUM_KINDS-1:0] pick;
	logic [cfbp_pkg::NUM_KINDS-1:0] rest;
	logic                           fire;
	logic                           is_final;
	logic [7:0]                     bank_q;
	logic                           out_valid_q;
	cfbp_pkg::bank_write_t          out_q;
	cfbp_pkg::bank_desc_t           desc;
	cfbp_pkg::bank_mode_t           mode;
	cfbp_pkg::bank_write_t          beat;

	assign pending = head_valid ? (head.valid & ~done_q) : '0;

	always_comb begin
		if (|(head.first & pending)) begin
			pick = head.first & pending;
		end else begin
			pick = pending & (~pending + 1'b1);
		end
	end

	assign rest      = pending & ~pick;
	assign fire      = (|pending) && (!out_valid_q || pop);
	assign is_final  = head.last && (rest == '0);
	assign head_done = fire && (rest == '0);

	always_comb begin
		if (pick[cfbp_pkg::KIND_LIST]) begin
			desc = head.desc[cfbp_pkg::KIND_LIST];
			mode = cfbp_pkg::MODE_LIST;
		end else if (pick[cfbp_pkg::KIND_PAIR]) begin
			desc = head.desc[cfbp_pkg::KIND_PAIR];
			mode = cfbp_pkg::MODE_PAIR;
		end else begin
			desc = head.desc[cfbp_pkg::KIND_EXT];
			mode = cfbp_pkg::MODE_EXT;
		end
	end

	always_comb begin
		beat             = '0;
		beat.bank_number = bank_q;
		beat.bank_mode   = mode;
		beat.fifo_select = bank_q[0];
		beat.final_write = is_final;
		if (mode == cfbp_pkg::MODE_EXT) begin
			beat.word_a = {desc.w0, 3'b100};
			beat.word_b = {desc.w1, 3'b100};
		end else begin
			beat.word_a = {16'd0, desc.w0[10:0], 5'd0};
			beat.word_b = {16'd0, desc.w1[10:0], 5'd0};
			beat.word_c = {desc.w2, 5'd0};
			beat.word_d = {desc.w3, 5'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			bank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				done_q <= head_done ? '0 : (done_q | pick);
			end
			if (bank_load) begin
				bank_q <= first_bank;
			end else if (fire) begin
				bank_q <= is_final ? first_bank : bank_q + 8'd1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= beat;
		end
	end

	assign empty      = !out_valid_q;
	assign bank_write = out_q;

endmodule

// ===== rtl/can_filter_bank_packer.sv =====
// CAN filter bank packer top level: register port, front end, bundle queue, back end.
// Takes one filter entry per cycle whenever full is low, and hands out up to one
// bank write per cycle. An entry that fills a bank, or a last entry that flushes the
// partial banks, turns into one bundle of one to three writes in a two-deep queue;
// the back end drains a bundle at one write per clock while the output is free or
// popped, so a last entry takes up to three writes on the result side while the front
// keeps taking entries until the queue fills. A write passes the bundle queue and the
// output register before it shows on the result ports. The bank counter reloads from
// first_bank after the final write of each list and on every write of first_bank.
`include "can_filter_bank_packer_defines.svh"

module can_filter_bank_packer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  cfbp_pkg::entry_t      entry,
	output logic                  empty,
	input  logic                  pop,
	output cfbp_pkg::bank_write_t bank_write,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [7:0]        first_bank_q;
	logic              cfg_we;
	logic              accept;
	logic              has_write;
	cfbp_pkg::bundle_t front_bundle;
	cfbp_pkg::bundle_t head;
	logic              head_valid;
	logic              head_done;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == cfbp_pkg::REG_FIRST_BANK);
	assign prdata = (paddr[2] == cfbp_pkg::REG_FIRST_BANK) ? {24'd0, first_bank_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_bank_q <= '0;
		end else if (cfg_we) begin
			first_bank_q <= pwdata[7:0];
		end
	end

	assign accept = push && !full;

	cfbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.entry     (entry),
		.bundle    (front_bundle),
		.has_write (has_write)
	);

	cfbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && has_write),
		.wr_data (front_bundle),
		.rd_en   (head_done),
		.rd_data (head),
		.avail   (head_valid),
		.full    (full)
	);

	cfbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_done  (head_done),
		.first_bank (cfg_we ? pwdata[7:0] : first_bank_q),
		.bank_load  (cfg_we),
		.pop        (pop),
		.empty      (empty),
		.bank_write (bank_write)
	);

	`CFBP_ASSERT_NEXT(a_drain, head_valid && (empty || pop), !empty, "queued write not issued")
	`CFBP_ASSERT_NOW(a_ext_zero, !empty && (bank_write.bank_mode == cfbp_pkg::MODE_EXT), (bank_write.word_c == 16'd0) && (bank_write.word_d == 16'd0), "ext bank with nonzero c/d words")
	`CFBP_ASSERT_NOW(a_std_align, !empty && (bank_write.bank_mode != cfbp_pkg::MODE_EXT), (bank_write.word_a[31:16] == 16'd0) && (bank_write.word_b[4:0] == 5'd0), "standard bank word misaligned")

endmodule
